// ===== rtl/psq_pkg.sv =====
// ----------------------------------------------------------------------------
// psq_pkg
// Shared types and constants for the positional sequence store.
// ----------------------------------------------------------------------------
package psq_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 5;
  localparam int DATA_W   = 32;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_READ   = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD       = 2'd1,
    CELL_TAKE_LEFT  = 2'd2,
    CELL_TAKE_RIGHT = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
  } cell_ctrl_t;

endpackage

// ===== rtl/psq_cell.sv =====
// ----------------------------------------------------------------------------
// psq_cell
// One entry of the sequence. Holds its value, loads a new one, or takes the
// value of its lower or upper neighbor when the sequence shifts.
// ----------------------------------------------------------------------------
module psq_cell (
  input  logic                       clk,
  input  psq_pkg::cell_ctrl_t        ctrl,
  input  logic [psq_pkg::DATA_W-1:0] load_data,
  input  logic [psq_pkg::DATA_W-1:0] left_data,
  input  logic [psq_pkg::DATA_W-1:0] right_data,
  output logic [psq_pkg::DATA_W-1:0] data_r
);

  logic [psq_pkg::DATA_W-1:0] data_nxt;

  always_comb begin
    case (ctrl.op)
      psq_pkg::CELL_LOAD:       data_nxt = load_data;
      psq_pkg::CELL_TAKE_LEFT:  data_nxt = left_data;
      psq_pkg::CELL_TAKE_RIGHT: data_nxt = right_data;
      default:                  data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

// ===== rtl/positional_sequence_store_core.sv =====
// ----------------------------------------------------------------------------
// positional_sequence_store_core
// Ordered sequence of signed 32-bit values with insert, remove and read by
// position.
// ----------------------------------------------------------------------------
// One request per item, one result per item. Each entry sits in its own cell;
// an insert or remove shifts all cells above the position in the same cycle,
// so a request is decoded, applied and its result registered at the edge that accepts it.
// The block takes one item per cycle for as long as the result side keeps
// taking results; a waiting result stalls the input only while it is not
// taken. Results carry the length after the request and a status: ok, position
// out of range, or store full. On any error the sequence is left unchanged.
module positional_sequence_store_core (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [4:0] position, [36:5] value, [39:37] zero
  input  logic [1:0]  in_tuser,   // [1:0] req_type

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] item_value, [36:32] length, [39:37] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int N = psq_pkg::CAPACITY;

  logic                        accept;
  psq_pkg::req_t               req;
  logic [psq_pkg::POS_W-1:0]   pos;
  logic [psq_pkg::DATA_W-1:0]  val;

  logic [psq_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                        out_valid_r;
  logic [psq_pkg::DATA_W-1:0]  item_r, item_nxt;
  logic [psq_pkg::CNT_W-1:0]   len_r;
  psq_pkg::status_t            status_r, status_nxt;

  logic                        ins_ok, rem_ok;
  logic [psq_pkg::DATA_W-1:0]  cell_q [N];
  logic [psq_pkg::DATA_W-1:0]  sel_q;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign req       = psq_pkg::req_t'(in_tuser);
  assign pos       = in_tdata[psq_pkg::POS_W-1:0];
  assign val       = in_tdata[psq_pkg::POS_W +: psq_pkg::DATA_W];

  assign sel_q = cell_q[pos[psq_pkg::IDX_W-1:0]];

  always_comb begin
    ins_ok     = 1'b0;
    rem_ok     = 1'b0;
    item_nxt   = '0;
    status_nxt = psq_pkg::ST_OK;
    cnt_nxt    = cnt_r;
    unique case (req)
      psq_pkg::REQ_INSERT: begin
        // position check has priority over the full check
        if (pos > cnt_r) begin
          status_nxt = psq_pkg::ST_RANGE;
        end else if (cnt_r == psq_pkg::CNT_W'(N)) begin
          status_nxt = psq_pkg::ST_FULL;
        end else begin
          ins_ok  = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      psq_pkg::REQ_REMOVE: begin
        if (pos >= cnt_r) begin
          status_nxt = psq_pkg::ST_RANGE;
        end else begin
          rem_ok   = 1'b1;
          item_nxt = sel_q;
          cnt_nxt  = cnt_r - 1'b1;
        end
      end
      psq_pkg::REQ_READ: begin
        if (pos >= cnt_r) begin
          status_nxt = psq_pkg::ST_RANGE;
        end else begin
          item_nxt = sel_q;
        end
      end
      default: ;
    endcase
  end

  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_cell
      psq_pkg::cell_ctrl_t        ctrl;
      logic [psq_pkg::DATA_W-1:0] left_d, right_d;

      if (k == 0) begin : g_lo
        assign left_d = '0;
      end else begin : g_lo
        assign left_d = cell_q[k-1];
      end
      if (k == N - 1) begin : g_hi
        assign right_d = '0;
      end else begin : g_hi
        assign right_d = cell_q[k+1];
      end

      // cells above the position shift up on insert, the position and above
      // shift down on remove; entries past the length are don't-care
      always_comb begin
        ctrl.op = psq_pkg::CELL_HOLD;
        if (accept && ins_ok) begin
          if (pos == psq_pkg::POS_W'(k)) begin
            ctrl.op = psq_pkg::CELL_LOAD;
          end else if (pos < psq_pkg::POS_W'(k)) begin
            ctrl.op = psq_pkg::CELL_TAKE_LEFT;
          end
        end else if (accept && rem_ok && pos <= psq_pkg::POS_W'(k)) begin
          ctrl.op = psq_pkg::CELL_TAKE_RIGHT;
        end
      end

      psq_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .load_data  (val),
        .left_data  (left_d),
        .right_data (right_d),
        .data_r     (cell_q[k])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r   <= item_nxt;
      len_r    <= cnt_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, len_r, item_r};
  assign out_tuser  = status_r;

endmodule
